FILE: sv/dd_pkg.sv
// Shared types, constants and calendar tables for the date difference block.
package dd_pkg;

    localparam int unsigned DayW   = 5;
    localparam int unsigned MonthW = 4;
    localparam int unsigned YearW  = 14;
    localparam int unsigned CountW = 22;
    localparam int unsigned DayNumW = 23;

    localparam logic [14:0] MAX_YEAR = 15'd9999;
    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    typedef struct packed {
        logic [DayW-1:0]   start_day;
        logic [MonthW-1:0] start_month;
        logic [YearW-1:0]  start_year;
        logic [DayW-1:0]   end_day;
        logic [MonthW-1:0] end_month;
        logic [YearW-1:0]  end_year;
    } dd_dates_t;

    typedef struct packed {
        logic [CountW-1:0] day_count;
        logic              invalid_date;
    } dd_result_t;

    typedef struct packed {
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
    } dd_date_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } dd_load_t;

    // Days before the first of a month, counted from March 1.
    function automatic logic [8:0] dd_doy_base(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Month length in a common year.
    function automatic logic [4:0] dd_month_len(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/dd_day_number.sv
// Three-stage pipeline: date check and serial day number for one date.
module dd_day_number (
    input  logic                     clk,
    input  dd_pkg::dd_load_t         load,
    input  dd_pkg::dd_date_t         date,
    output logic [dd_pkg::DayNumW-1:0] day_num,
    output logic                     date_ok
);
    import dd_pkg::*;

    // stage 1
    logic [4:0]  s1_day_reg,  s1_day_next;
    logic [1:0]  s1_ylow_reg, s1_ylow_next;
    logic [11:0] s1_x_reg,    s1_x_next;
    logic [7:0]  s1_q25_reg,  s1_q25_next;
    logic [14:0] s1_yy_reg,   s1_yy_next;
    logic [5:0]  s1_era_reg,  s1_era_next;
    logic [8:0]  s1_doyb_reg, s1_doyb_next;
    logic [4:0]  s1_mlen_reg, s1_mlen_next;
    logic        s1_feb_reg,  s1_feb_next;
    logic        s1_mok_reg,  s1_mok_next;
    logic        s1_yok_reg,  s1_yok_next;

    logic [24:0] q25_prod;
    logic [21:0] era_prod;
    logic [3:0]  mp;

    always_comb
    begin
        s1_day_next  = date.day;
        s1_ylow_next = date.year[1:0];
        s1_x_next    = date.year[13:2];
        q25_prod     = 25'(date.year[13:2]) * 25'd5243;
        s1_q25_next  = q25_prod[24:17];
        s1_yy_next   = 15'(date.year) + 15'd400 - ((date.month <= 4'd2) ? 15'd1 : 15'd0);
        era_prod     = 22'(s1_yy_next[14:4]) * 22'd1311;
        s1_era_next  = era_prod[20:15];
        mp           = (date.month > 4'd2) ? (date.month - 4'd3) : (date.month + 4'd9);
        s1_doyb_next = dd_doy_base(mp);
        s1_mlen_next = dd_month_len(date.month);
        s1_feb_next  = (date.month == 4'd2);
        s1_mok_next  = date.month inside {[4'd1:4'd12]};
        s1_yok_next  = ({1'b0, date.year} <= MAX_YEAR);
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            s1_day_reg  <= s1_day_next;
            s1_ylow_reg <= s1_ylow_next;
            s1_x_reg    <= s1_x_next;
            s1_q25_reg  <= s1_q25_next;
            s1_yy_reg   <= s1_yy_next;
            s1_era_reg  <= s1_era_next;
            s1_doyb_reg <= s1_doyb_next;
            s1_mlen_reg <= s1_mlen_next;
            s1_feb_reg  <= s1_feb_next;
            s1_mok_reg  <= s1_mok_next;
            s1_yok_reg  <= s1_yok_next;
        end
    end

    // stage 2
    logic        s2_ok_reg,  s2_ok_next;
    logic [8:0]  s2_yoe_reg, s2_yoe_next;
    logic [8:0]  s2_doy_reg, s2_doy_next;
    logic [5:0]  s2_era_reg, s2_era_next;

    logic [12:0] back25;
    logic        leap;
    logic [4:0]  mlen_eff;
    logic [14:0] era400;
    logic [14:0] yoe_full;

    always_comb
    begin
        back25      = 13'(s1_q25_reg) * 13'd25;
        leap        = (s1_ylow_reg == 2'd0) &&
                      ((back25 != 13'(s1_x_reg)) || (s1_q25_reg[1:0] == 2'd0));
        mlen_eff    = s1_mlen_reg + ((s1_feb_reg && leap) ? 5'd1 : 5'd0);
        s2_ok_next  = s1_mok_reg && s1_yok_reg && (s1_day_reg != 5'd0) &&
                      (s1_day_reg <= mlen_eff);
        era400      = 15'(s1_era_reg) * 15'd400;
        yoe_full    = s1_yy_reg - era400;
        s2_yoe_next = yoe_full[8:0];
        s2_doy_next = s1_doyb_reg + 9'(s1_day_reg) - 9'd1;
        s2_era_next = s1_era_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            s2_ok_reg  <= s2_ok_next;
            s2_yoe_reg <= s2_yoe_next;
            s2_doy_reg <= s2_doy_next;
            s2_era_reg <= s2_era_next;
        end
    end

    // stage 3
    logic [DayNumW-1:0] s3_num_reg, s3_num_next;
    logic               s3_ok_reg,  s3_ok_next;

    logic [6:0]  q4;
    logic [11:0] c100;
    logic [17:0] doe;

    always_comb
    begin
        q4          = s2_yoe_reg[8:2];
        c100        = 12'(q4) * 12'd41;
        doe         = 18'(s2_yoe_reg) * 18'd365 + 18'(q4) - 18'(c100[11:10]) +
                      18'(s2_doy_reg);
        s3_num_next = DayNumW'(s2_era_reg) * DayNumW'(146097) + DayNumW'(doe);
        s3_ok_next  = s2_ok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            s3_num_reg <= s3_num_next;
            s3_ok_reg  <= s3_ok_next;
        end
    end

    assign day_num = s3_num_reg;
    assign date_ok = s3_ok_reg;

endmodule

FILE: sv/date_difference_in_days.sv
// Top level of the Gregorian date difference block.
//
// Date pairs enter on the dates channel (date_valid / date_stall) and results
// leave on the result channel (result_valid / result_stall); an item moves at
// a clock edge with valid high and stall low. Each result holds day_count,
// the number of days from start to end (0 when the end is not after the
// start), and invalid_date, set when either date is not a real calendar date
// or its year is past MAX_YEAR; day_count is then 0.
// cfg_write with cfg_data sets include_end_day, which adds one to a valid
// count. Change it only while the block holds no item.
// The edge that accepts a date pair loads the first of three day-number stages,
// run in parallel for both dates; the pair then passes through the other two,
// and a fourth register, the output register, subtracts, adjusts and saturates.
// Throughput is one item per cycle while result_stall is low. When result_stall
// is high the held result stays put; bubbles in the pipeline still fill, and
// date_stall rises only when every stage is full.
// Reset (rst_n low) empties the pipeline and clears include_end_day.
module date_difference_in_days (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               date_valid,
    output logic               date_stall,
    input  dd_pkg::dd_dates_t  dates,
    output logic               result_valid,
    input  logic               result_stall,
    output dd_pkg::dd_result_t result,
    input  logic               cfg_write,
    input  logic               cfg_data
);
    import dd_pkg::*;

    logic       include_end_reg;
    logic [2:0] v_reg, v_next;
    logic       out_v_reg, out_v_next;
    dd_result_t out_reg, out_next;

    dd_load_t   load;
    logic       load_out;

    logic [DayNumW-1:0] a_num, b_num;
    logic               a_ok, b_ok;
    dd_date_t           start_date, end_date;

    logic [DayNumW-1:0] diff;
    logic [DayNumW:0]   total;

    assign start_date = '{day: dates.start_day, month: dates.start_month,
                          year: dates.start_year};
    assign end_date   = '{day: dates.end_day, month: dates.end_month,
                          year: dates.end_year};

    always_comb
    begin
        load_out = !out_v_reg || !result_stall;
        load.s3  = !v_reg[2] || load_out;
        load.s2  = !v_reg[1] || load.s3;
        load.s1  = !v_reg[0] || load.s2;
    end

    dd_day_number u_start (
        .clk     (clk),
        .load    (load),
        .date    (start_date),
        .day_num (a_num),
        .date_ok (a_ok)
    );

    dd_day_number u_end (
        .clk     (clk),
        .load    (load),
        .date    (end_date),
        .day_num (b_num),
        .date_ok (b_ok)
    );

    always_comb
    begin
        v_next[0] = load.s1 ? date_valid : v_reg[0];
        v_next[1] = load.s2 ? v_reg[0]   : v_reg[1];
        v_next[2] = load.s3 ? v_reg[1]   : v_reg[2];
        out_v_next = load_out ? v_reg[2] : out_v_reg;
    end

    always_comb
    begin
        diff  = (b_num > a_num) ? (b_num - a_num) : '0;
        total = (DayNumW+1)'(diff) + (DayNumW+1)'(include_end_reg);
        out_next = out_reg;
        if (load_out)
        begin
            if (!(a_ok && b_ok))
            begin
                out_next.day_count    = '0;
                out_next.invalid_date = 1'b1;
            end
            else
            begin
                out_next.day_count    = (total > (DayNumW+1)'(COUNT_MAX)) ?
                                        COUNT_MAX : total[CountW-1:0];
                out_next.invalid_date = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            include_end_reg <= 1'b0;
            v_reg           <= '0;
            out_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                include_end_reg <= cfg_data;
            end
            v_reg     <= v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign date_stall   = !load.s1;
    assign result_valid = out_v_reg;
    assign result       = out_reg;

endmodule

FILE: sv/dd_checker.sv
// Port-level checks for the date difference block, bound to its top level.
module dd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               date_stall,
    input logic               result_valid,
    input logic               result_stall,
    input dd_pkg::dd_result_t result
);
    import dd_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result item dropped while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.invalid_date |-> result.day_count == '0)
        else $error("invalid date with nonzero day count");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        date_stall |-> result_valid && result_stall)
        else $error("date stall without a blocked result");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result item changed");

endmodule

bind date_difference_in_days dd_checker u_dd_checker (.*);

FILE: bench/date_difference_in_days_tb.sv
// Self-checking testbench for the date difference block: directed and random date pairs.
module date_difference_in_days_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dd_pkg::*;

    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned RANDOM_ITEMS = 1650;

    logic       clk;
    logic       rst_n;
    logic       date_valid;
    logic       date_stall;
    dd_dates_t  dates;
    logic       result_valid;
    logic       result_stall;
    dd_result_t result;
    logic       cfg_write;
    logic       cfg_data;

    dd_result_t  span_due[$];
    bit          include_end;
    bit          steady;
    int unsigned fail_count;
    int unsigned idle_cycles;

    date_difference_in_days dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .date_valid   (date_valid),
        .date_stall   (date_stall),
        .dates        (dates),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int unsigned days_before_month(input int unsigned m);
        case (m)
            1:       return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    function automatic bit real_date(input int unsigned d, input int unsigned m,
                                     input int unsigned y);
        if (y > MAX_YEAR || m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= days_in_month(y, m);
    endfunction

    // Days since January 1 of year 0, year 0 counted as leap.
    function automatic int unsigned serial_day(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned n;
        n = 365 * y;
        if (y > 0)
            n += (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
        n += days_before_month(m) + d - 1;
        if (m > 2 && is_leap(y))
            n += 1;
        return n;
    endfunction

    function automatic dd_result_t span_of(input dd_dates_t p, input bit incl);
        dd_result_t  r;
        int unsigned a;
        int unsigned b;
        int unsigned n;
        r = '0;
        if (!real_date(p.start_day, p.start_month, p.start_year) ||
            !real_date(p.end_day, p.end_month, p.end_year))
        begin
            r.invalid_date = 1'b1;
            return r;
        end
        a = serial_day(p.start_day, p.start_month, p.start_year);
        b = serial_day(p.end_day, p.end_month, p.end_year);
        n = (b > a) ? b - a : 0;
        if (incl)
            n += 1;
        if (n > COUNT_MAX)
            n = COUNT_MAX;
        r.day_count = CountW'(n);
        return r;
    endfunction

    function automatic dd_dates_t pair(input int unsigned sd, input int unsigned sm,
                                       input int unsigned sy, input int unsigned ed,
                                       input int unsigned em, input int unsigned ey);
        dd_dates_t p;
        p.start_day   = DayW'(sd);
        p.start_month = MonthW'(sm);
        p.start_year  = YearW'(sy);
        p.end_day     = DayW'(ed);
        p.end_month   = MonthW'(em);
        p.end_year    = YearW'(ey);
        return p;
    endfunction

    function automatic int unsigned pick_year();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(MAX_YEAR - 3, MAX_YEAR);
            2:       return $urandom_range(0, 99) * 100;
            default: return $urandom_range(0, MAX_YEAR);
        endcase
    endfunction

    function automatic dd_date_t pick_date();
        dd_date_t    t;
        int unsigned y;
        int unsigned m;
        y = pick_year();
        m = $urandom_range(1, 12);
        t.year  = YearW'(y);
        t.month = MonthW'(m);
        t.day   = DayW'($urandom_range(1, days_in_month(y, m)));
        return t;
    endfunction

    function automatic dd_date_t raw_date();
        dd_date_t t;
        t.day   = DayW'($urandom);
        t.month = MonthW'($urandom);
        t.year  = YearW'($urandom);
        return t;
    endfunction

    function automatic dd_dates_t pick_pair();
        dd_date_t    s;
        dd_date_t    e;
        int unsigned r;
        int unsigned m;
        r = $urandom_range(0, 99);
        s = pick_date();
        e = pick_date();
        if (r < 5)
            e = s;
        else if (r < 40)
        begin
            m = $urandom_range(1, 12);
            e.year  = s.year;
            e.month = MonthW'(m);
            e.day   = DayW'($urandom_range(1, days_in_month(s.year, m)));
        end
        else if (r < 80)
            ;
        else if (r < 88)
            s = raw_date();
        else if (r < 96)
            e = raw_date();
        else
        begin
            s = raw_date();
            e = raw_date();
        end
        return pair(s.day, s.month, s.year, e.day, e.month, e.year);
    endfunction

    task automatic send_dates(input dd_dates_t p);
        int unsigned gap;
        gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 17);
        if (gap > 0)
        begin
            date_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        date_valid <= 1'b1;
        dates      <= p;
        @(posedge clk);
        while (date_stall) @(posedge clk);
        span_due.push_back(span_of(p, include_end));
    endtask

    task automatic wait_drained();
        date_valid <= 1'b0;
        while (span_due.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_include(input bit v);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write   <= 1'b0;
        include_end = v;
    endtask

    task automatic test_calendar_edges();
        send_dates(pair(1, 1, 0, 31, 12, 9999));
        send_dates(pair(31, 12, 9999, 1, 1, 0));
        send_dates(pair(15, 6, 2020, 15, 6, 2020));
        send_dates(pair(28, 2, 2023, 1, 3, 2023));
        send_dates(pair(28, 2, 2024, 1, 3, 2024));
        send_dates(pair(28, 2, 1900, 1, 3, 1900));
        send_dates(pair(28, 2, 2000, 1, 3, 2000));
        send_dates(pair(31, 12, 1999, 1, 1, 2000));
        send_dates(pair(29, 2, 2000, 29, 2, 2004));
        send_dates(pair(1, 1, 0, 1, 3, 0));
        send_dates(pair(1, 3, 0, 1, 3, 400));
        send_dates(pair(31, 1, 9999, 28, 2, 9999));
    endtask

    task automatic test_invalid_dates();
        send_dates(pair(29, 2, 1900, 1, 3, 1900));
        send_dates(pair(1, 1, 2023, 29, 2, 2023));
        send_dates(pair(30, 2, 2024, 1, 3, 2024));
        send_dates(pair(31, 4, 2021, 1, 5, 2021));
        send_dates(pair(0, 5, 2021, 1, 6, 2021));
        send_dates(pair(1, 1, 2021, 1, 0, 2021));
        send_dates(pair(1, 1, 2021, 1, 13, 2021));
        send_dates(pair(31, 15, 16383, 31, 15, 16383));
        send_dates(pair(1, 1, 9999, 1, 1, 10000));
        send_dates(pair(1, 1, 10000, 1, 1, 9999));
        send_dates(pair(0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_include_end_day();
        set_include(1'b1);
        send_dates(pair(15, 6, 2020, 15, 6, 2020));
        send_dates(pair(2, 1, 2020, 1, 1, 2020));
        send_dates(pair(1, 1, 0, 31, 12, 9999));
        send_dates(pair(31, 12, 2023, 1, 1, 2024));
        send_dates(pair(29, 2, 2023, 1, 3, 2023));
        set_include(1'b0);
        send_dates(pair(31, 12, 2023, 1, 1, 2024));
    endtask

    task automatic test_random_pairs();
        int unsigned i;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 300 == 299)
                set_include(~include_end);
            if (i % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_dates(pick_pair());
        end
        steady = 1'b0;
    endtask

    initial
    begin : stall_gen
        int unsigned n;
        result_stall <= 1'b0;
        forever
        begin
            n = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 17);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(rst_n && result_valid === 1'b1 && !result_stall)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        dd_result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (span_due.size() == 0)
            begin
                $error("unexpected result: day_count %0d invalid_date %0d",
                       result.day_count, result.invalid_date);
                fail_count++;
            end
            else
            begin
                want = span_due.pop_front();
                if (result.day_count !== want.day_count)
                begin
                    $error("day_count expected %0d actual %0d",
                           want.day_count, result.day_count);
                    fail_count++;
                end
                if (result.invalid_date !== want.invalid_date)
                begin
                    $error("invalid_date expected %0d actual %0d",
                           want.invalid_date, result.invalid_date);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (date_valid && !date_stall) || (result_valid && !result_stall)
            || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[date_difference_in_days] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n       <= 1'b0;
        date_valid  <= 1'b0;
        dates       <= '0;
        cfg_write   <= 1'b0;
        cfg_data    <= 1'b0;
        include_end = 1'b0;
        steady      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calendar_edges();
        test_invalid_dates();
        test_include_end_day();
        test_random_pairs();
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[date_difference_in_days] OK");
        else
            $display("[date_difference_in_days] ERROR");
        $finish;
    end
endmodule

FILE: sim.f
sv/dd_pkg.sv
sv/dd_day_number.sv
sv/date_difference_in_days.sv
sv/dd_checker.sv
bench/date_difference_in_days_tb.sv
